@@ design/stk_pkg.sv @@
// Shared types and constants for the stack engine.
package stk_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int DEPTH_W     = 5;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_DUP     = 3'd2,
        OP_SWAP    = 3'd3,
        OP_REVERSE = 3'd4
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_IGNORED  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // cell load select
    typedef enum logic [1:0] {
        SEL_HOLD = 2'd0,
        SEL_PREV = 2'd1,
        SEL_NEXT = 2'd2
    } t_sel;

endpackage

@@ design/stk_cell.sv @@
// One stack cell: holds a word, loads from either neighbour or holds.
module stk_cell (
    input  logic                                i_clk,
    input  stk_pkg::t_sel                       i_sel,
    input  logic signed [stk_pkg::DATA_W-1:0]   i_prev,
    input  logic signed [stk_pkg::DATA_W-1:0]   i_next,
    output logic signed [stk_pkg::DATA_W-1:0]   o_value
);

    logic signed [stk_pkg::DATA_W-1:0] r_value;
    logic signed [stk_pkg::DATA_W-1:0] n_value;

    always_comb begin
        unique case (i_sel)
            stk_pkg::SEL_PREV: n_value = i_prev;
            stk_pkg::SEL_NEXT: n_value = i_next;
            default:           n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

@@ design/stack_engine_with_dup_swap_reverse.sv @@
// Stack engine top level: cell row, command control and result register.
// Bounded LIFO of signed 32-bit words kept in a row of cells, top of stack in
// cell 0. Push, pop, dup and swap complete in the cycle the command word is
// accepted and their result word is valid in the next cycle. The result word
// sits in a single output register, so a new command is accepted only when that
// register is empty or its word is taken in the same cycle. With the result side
// always ready this gives one command per cycle outside a reverse. Reverse on
// n >= 2 entries is accepted and then runs n odd-even exchange passes along
// the cell row, one per cycle, during which no command is accepted. Its result
// word is valid after the last pass. Push or dup on a full stack is dropped
// with overflow status.
module stack_engine_with_dup_swap_reverse #(
    parameter int STACK_DEPTH = stk_pkg::STACK_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [2:0] opcode, [34:3] push_value, [39:35] zero
    input  logic [stk_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [31:0] top_value, [36:32] depth_count, [38:37] status, [39] zero
    output logic [stk_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_REV  = 2'b10
    } t_state;

    t_state                               r_state, n_state;
    logic [CW-1:0]                        r_fill, n_fill;
    logic [CW-1:0]                        r_phase, n_phase;
    logic                                 r_out_valid, n_out_valid;
    logic signed [stk_pkg::DATA_W-1:0]    r_out_top;
    logic [stk_pkg::DEPTH_W-1:0]          r_out_depth;
    stk_pkg::t_status                     r_out_status;

    stk_pkg::t_sel                        w_sel [STACK_DEPTH];
    logic signed [stk_pkg::DATA_W-1:0]    w_val [STACK_DEPTH];
    logic signed [stk_pkg::DATA_W-1:0]    w_push;
    logic signed [stk_pkg::DATA_W-1:0]    w_new_top;
    stk_pkg::t_opcode                     w_op;
    stk_pkg::t_status                     w_status;
    logic                                 w_accept;
    logic                                 w_load_out;
    logic                                 w_par;
    logic [CW+stk_pkg::DEPTH_W-1:0]       w_fill_ext;

    assign w_op     = stk_pkg::t_opcode'(i_s_axis_tdata[2:0]);
    assign w_push   = i_s_axis_tdata[34:3];
    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_par    = r_phase[0];

    // cell row
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic signed [stk_pkg::DATA_W-1:0] w_prev;
        logic signed [stk_pkg::DATA_W-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = w_push;
        end else begin : g_mid
            assign w_prev = w_val[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_last
            assign w_next = w_val[g];
        end else begin : g_inner
            assign w_next = w_val[g+1];
        end
        stk_cell u_cell (
            .i_clk   (i_clk),
            .i_sel   (w_sel[g]),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_value (w_val[g])
        );
    end

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_phase    = r_phase;
        w_status   = stk_pkg::ST_DONE;
        w_load_out = 1'b0;
        for (int i = 0; i < STACK_DEPTH; i++) begin
            w_sel[i] = stk_pkg::SEL_HOLD;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_load_out = 1'b1;
                    case (w_op)
                        stk_pkg::OP_PUSH: begin
                            if (r_fill >= CW'(STACK_DEPTH)) begin
                                w_status = stk_pkg::ST_OVERFLOW;
                            end else begin
                                for (int i = 0; i < STACK_DEPTH; i++) begin
                                    w_sel[i] = stk_pkg::SEL_PREV;
                                end
                                n_fill = r_fill + CW'(1);
                            end
                        end
                        stk_pkg::OP_POP: begin
                            if (r_fill == '0) begin
                                w_status = stk_pkg::ST_IGNORED;
                            end else begin
                                for (int i = 0; i < STACK_DEPTH; i++) begin
                                    w_sel[i] = stk_pkg::SEL_NEXT;
                                end
                                n_fill = r_fill - CW'(1);
                            end
                        end
                        stk_pkg::OP_DUP: begin
                            if (r_fill == '0) begin
                                w_status = stk_pkg::ST_IGNORED;
                            end else if (r_fill >= CW'(STACK_DEPTH)) begin
                                w_status = stk_pkg::ST_OVERFLOW;
                            end else begin
                                for (int i = 1; i < STACK_DEPTH; i++) begin
                                    w_sel[i] = stk_pkg::SEL_PREV;
                                end
                                n_fill = r_fill + CW'(1);
                            end
                        end
                        stk_pkg::OP_SWAP: begin
                            if (r_fill < CW'(2)) begin
                                w_status = stk_pkg::ST_IGNORED;
                            end else begin
                                w_sel[0] = stk_pkg::SEL_NEXT;
                                w_sel[1] = stk_pkg::SEL_PREV;
                            end
                        end
                        stk_pkg::OP_REVERSE: begin
                            if (r_fill >= CW'(2)) begin
                                w_load_out = 1'b0;
                                n_state    = S_REV;
                                n_phase    = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_REV: begin
                // odd-even exchange pass over the occupied cells
                for (int i = 0; i < STACK_DEPTH; i++) begin
                    if ((i[0] == w_par) && (CW'(i + 1) < r_fill)) begin
                        w_sel[i] = stk_pkg::SEL_NEXT;
                    end else if ((i >= 1) && (i[0] != w_par) && (CW'(i) < r_fill)) begin
                        w_sel[i] = stk_pkg::SEL_PREV;
                    end
                end
                n_phase = r_phase + CW'(1);
                if (r_phase == r_fill - CW'(1)) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        case (w_sel[0])
            stk_pkg::SEL_PREV: w_new_top = w_push;
            stk_pkg::SEL_NEXT: w_new_top = w_val[1];
            default:           w_new_top = w_val[0];
        endcase
    end

    assign w_fill_ext = (CW + stk_pkg::DEPTH_W)'(n_fill);

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_top    <= (n_fill == '0) ? '0 : w_new_top;
            r_out_depth  <= w_fill_ext[stk_pkg::DEPTH_W-1:0];
            r_out_status <= w_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_status, r_out_depth, r_out_top};

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(STACK_DEPTH))
        else $error("fill count beyond capacity");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REV) |-> (r_phase < r_fill))
        else $error("reverse pass count out of range");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == stk_pkg::OP_PUSH) && (r_fill < CW'(STACK_DEPTH)))
        |=> (r_fill == $past(r_fill) + CW'(1)))
        else $error("push did not grow the stack");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == stk_pkg::ST_OVERFLOW))
        |-> (r_fill == CW'(STACK_DEPTH)))
        else $error("overflow reported on a stack that is not full");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for the stack engine: stack tracker class, stream drivers and the run sequence.
module testbench;
    import stk_pkg::*;

    localparam logic [OP_W-1:0]   OP_SPARE_LO  = 3'd5;
    localparam logic [OP_W-1:0]   OP_SPARE_HI  = 3'd7;
    localparam logic [DATA_W-1:0] WORD_MIN     = 32'h8000_0000;
    localparam logic [DATA_W-1:0] WORD_MAX     = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] WORD_ONES    = 32'hffff_ffff;
    localparam int                PHASE_ITEMS  = 625;
    localparam int                HOLD_CYCLES  = 300;
    localparam int                REPORT_LIMIT = 10;
    localparam int                SETTLE_CYCLES = 40;

    typedef enum int {
        BURST_FILL,
        BURST_DRAIN,
        BURST_MIXED
    } t_burst;

    typedef struct packed {
        logic [DATA_W-1:0]  top;
        logic [DEPTH_W-1:0] depth;
        t_status            status;
    } t_stack_view;

    class stack_tracker;
        logic [DATA_W-1:0] cells [STACK_DEPTH];
        int unsigned       fill;
        t_stack_view       awaited [$];
        int unsigned       faults;

        function new();
            fill   = 0;
            faults = 0;
        endfunction

        // apply one accepted command word to the model and queue its result
        function void take_command(logic [OP_W-1:0] op, logic [DATA_W-1:0] word);
            t_stack_view       view;
            logic [DATA_W-1:0] held;
            int unsigned       i;
            view.status = ST_DONE;
            case (op)
                OP_PUSH: begin
                    if (fill >= STACK_DEPTH) begin
                        view.status = ST_OVERFLOW;
                    end else begin
                        cells[fill] = word;
                        fill++;
                    end
                end
                OP_POP: begin
                    if (fill == 0) begin
                        view.status = ST_IGNORED;
                    end else begin
                        fill--;
                    end
                end
                OP_DUP: begin
                    if (fill == 0) begin
                        view.status = ST_IGNORED;
                    end else if (fill >= STACK_DEPTH) begin
                        view.status = ST_OVERFLOW;
                    end else begin
                        cells[fill] = cells[fill-1];
                        fill++;
                    end
                end
                OP_SWAP: begin
                    if (fill < 2) begin
                        view.status = ST_IGNORED;
                    end else begin
                        held          = cells[fill-1];
                        cells[fill-1] = cells[fill-2];
                        cells[fill-2] = held;
                    end
                end
                OP_REVERSE: begin
                    for (i = 0; i < fill / 2; i++) begin
                        held            = cells[i];
                        cells[i]        = cells[fill-1-i];
                        cells[fill-1-i] = held;
                    end
                end
                default: begin
                end
            endcase
            view.top   = (fill == 0) ? '0 : cells[fill-1];
            view.depth = DEPTH_W'(fill);
            awaited    = {awaited, view};
        endfunction

        function void match_reply(logic [OUT_TDATA_W-1:0] word);
            t_stack_view seen;
            t_stack_view want;
            seen.top    = word[DATA_W-1:0];
            seen.depth  = word[DATA_W +: DEPTH_W];
            seen.status = t_status'(word[DATA_W+DEPTH_W +: STATUS_W]);
            if (awaited.size() == 0) begin
                if (faults < REPORT_LIMIT) begin
                    $display("unexpected result word: top=%h depth=%0d status=%0d",
                             seen.top, seen.depth, seen.status);
                end
                faults++;
                return;
            end
            want = awaited.pop_front();
            if (seen.top !== want.top || seen.depth !== want.depth ||
                seen.status !== want.status) begin
                if (faults < REPORT_LIMIT) begin
                    $display({"mismatch: want top=%h depth=%0d status=%0d,",
                              " got top=%h depth=%0d status=%0d"},
                             want.top, want.depth, want.status,
                             seen.top, seen.depth, seen.status);
                end
                faults++;
            end
        endfunction
    endclass

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;
    bit           hold_request  = 1'b0;
    stack_tracker tracker       = new();

    stack_engine_with_dup_swap_reverse dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        #1_500_000;
        $display("tb: failure");
        $finish;
    end

    // result side: check accepted words, randomise tready, honour long hold-offs
    initial begin : reply_sink
        int unsigned hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) begin
                tracker.match_reply(m_tdata);
            end
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_command(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] word);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {{(IN_TDATA_W-OP_W-DATA_W){1'b0}}, word, op};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        tracker.take_command(op, word);
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(15))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return WORD_ONES;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_opcode(t_burst mode);
        int unsigned r;
        int unsigned w_push;
        int unsigned w_pop;
        int unsigned w_dup;
        int unsigned w_swap;
        int unsigned w_rev;
        case (mode)
            BURST_FILL: begin
                w_push = 55; w_pop = 7;  w_dup = 20; w_swap = 8;  w_rev = 7;
            end
            BURST_DRAIN: begin
                w_push = 12; w_pop = 55; w_dup = 8;  w_swap = 10; w_rev = 12;
            end
            default: begin
                w_push = 28; w_pop = 24; w_dup = 14; w_swap = 15; w_rev = 15;
            end
        endcase
        r = $urandom_range(99);
        if (r < w_push) return OP_PUSH;
        r -= w_push;
        if (r < w_pop) return OP_POP;
        r -= w_pop;
        if (r < w_dup) return OP_DUP;
        r -= w_dup;
        if (r < w_swap) return OP_SWAP;
        r -= w_swap;
        if (r < w_rev) return OP_REVERSE;
        return OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    endfunction

    task automatic random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                input int unsigned items);
        int unsigned sent;
        int unsigned burst;
        t_burst      mode;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < items) begin
            mode  = t_burst'($urandom_range(BURST_MIXED, BURST_FILL));
            burst = $urandom_range(24, 4);
            repeat (burst) begin
                send_command(pick_opcode(mode), pick_word());
                sent++;
            end
        end
    endtask

    initial begin : run
        int op;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 16;
        recv_idle_pct = 80;

        // empty stack, then the spare opcodes
        send_command(OP_POP, $urandom);
        send_command(OP_DUP, $urandom);
        send_command(OP_SWAP, $urandom);
        send_command(OP_REVERSE, $urandom);
        for (op = OP_SPARE_LO; op <= OP_SPARE_HI; op++) begin
            send_command(OP_W'(op), $urandom);
        end
        // single entry, then up to five entries and back down to three
        send_command(OP_PUSH, WORD_MIN);
        send_command(OP_SWAP, $urandom);
        send_command(OP_REVERSE, $urandom);
        send_command(OP_DUP, $urandom);
        send_command(OP_PUSH, WORD_MAX);
        send_command(OP_SWAP, $urandom);
        send_command(OP_REVERSE, $urandom);
        send_command(OP_PUSH, WORD_ONES);
        send_command(OP_PUSH, '0);
        send_command(OP_REVERSE, $urandom);
        send_command(OP_POP, $urandom);
        send_command(OP_SWAP, $urandom);
        send_command(OP_POP, $urandom);

        random_phase(16, 80, PHASE_ITEMS);

        // pause until every result word is back
        s_tvalid <= 1'b0;
        do @(posedge clk); while (tracker.awaited.size() != 0);

        random_phase(80, 16, PHASE_ITEMS);

        hold_request = 1'b1;
        random_phase(0, 0, PHASE_ITEMS);

        s_tvalid <= 1'b0;
        do @(posedge clk); while (tracker.awaited.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.faults == 0 && tracker.awaited.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
